/* rtl/core/cpc_pkg.sv */
// ----------------------------------------------------------------------------
// cpc_pkg: shared types and constants of the cartesian/polar converter
// Holds the pipeline word, the operation code, fixed-point constants and the
// CORDIC step angle table (atan(2^-i) in centidegrees * 4096).
// ----------------------------------------------------------------------------
package cpc_pkg;

  // operation codes
  typedef enum logic {
    OP_TO_POLAR     = 1'b0,
    OP_TO_CARTESIAN = 1'b1
  } op_t;

  // datapath widths
  localparam int VEC_W = 42;   // cordic x/y vector
  localparam int ANG_W = 28;   // angle accumulator, centidegrees in Q12
  localparam int SQ_W  = 32;   // sum of squares
  localparam int RT_W  = 16;   // square root
  localparam int REM_W = 17;   // square root remainder

  localparam int CORDIC_STEPS = 20;
  localparam int SQRT_STEPS   = 16;

  // angle constants in centidegrees
  localparam int FULL_TURN_CD    = 36000;
  localparam int HALF_TURN_CD    = 18000;
  localparam int QUARTER_TURN_CD = 9000;

  localparam logic signed [ANG_W-1:0] HALF_TURN_Q12 = 28'sd73728000;
  localparam logic signed [ANG_W-1:0] HALF_LSB_Q12  = 28'sd2048;
  localparam logic signed [VEC_W-1:0] HALF_LSB_Q24  = 42'sd8388608;

  // cordic gain compensation, 0.6072529350 in Q24
  localparam logic [23:0] GAIN_Q24 = 24'd10188014;

  // step angles, atan(2^-i) degrees * 409600
  localparam logic [24:0] STEP_ANGLE [0:CORDIC_STEPS-1] = '{
    25'd18432000, 25'd10881045, 25'd5749245, 25'd2918407, 25'd1464867,
    25'd733147,   25'd366663,   25'd183343,  25'd91673,   25'd45837,
    25'd22918,    25'd11459,    25'd5730,    25'd2865,    25'd1432,
    25'd716,      25'd358,      25'd179,     25'd90,      25'd45
  };

  // word carried down the pipeline
  typedef struct packed {
    op_t                      op;
    logic                     flip;
    logic signed [VEC_W-1:0]  cx;
    logic signed [VEC_W-1:0]  cy;
    logic signed [ANG_W-1:0]  z;
    logic [SQ_W-1:0]          sq;
    logic [RT_W-1:0]          root;
    logic [REM_W-1:0]         rem;
    logic signed [15:0]       omega;
  } pipe_t;

endpackage

/* rtl/core/cpc_prep.sv */
// ----------------------------------------------------------------------------
// cpc_prep: two setup stages ahead of the cordic pipeline
// Stage A squares x and y, scales rho by the gain compensation and reduces
// theta into one turn. Stage B sums the squares, folds theta into the right
// half plane and loads the cordic vector and angle.
// ----------------------------------------------------------------------------
module cpc_prep (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  cpc_pkg::op_t        in_operation,
  input  logic signed [15:0]  in_x_velocity,
  input  logic signed [15:0]  in_y_velocity,
  input  logic [15:0]         in_rho,
  input  logic signed [16:0]  in_theta,
  input  logic signed [15:0]  in_omega,
  output logic                out_valid,
  output cpc_pkg::pipe_t      out_pipe
);

  // stage A
  logic                      va_r;
  cpc_pkg::op_t              op_a_r;
  logic signed [15:0]        omega_a_r;
  logic [31:0]               sqx_nxt, sqy_nxt, sqx_a_r, sqy_a_r;
  logic [39:0]               prod_nxt, prod_a_r;
  logic signed [18:0]        t_ext;
  logic signed [18:0]        t_sel;
  logic signed [15:0]        t_a_r;
  logic signed [16:0]        xa_nxt, ya_nxt, xa_a_r, ya_a_r;
  logic                      neg_a_r, ypos_a_r;

  // stage B
  logic                      vb_r;
  cpc_pkg::pipe_t            pipe_nxt, pipe_r;
  logic signed [15:0]        t_fold;
  logic                      flip;

  // squares and gain product
  assign sqx_nxt  = 32'(in_x_velocity * in_x_velocity);
  assign sqy_nxt  = 32'(in_y_velocity * in_y_velocity);
  assign prod_nxt = 40'(in_rho) * 40'(cpc_pkg::GAIN_Q24);

  // theta modulo one turn into [-half, half)
  assign t_ext = 19'(in_theta);
  always_comb begin
    if (t_ext >= 19'(3 * cpc_pkg::HALF_TURN_CD)) begin
      t_sel = t_ext - 19'(2 * cpc_pkg::FULL_TURN_CD);
    end else if (t_ext >= 19'(cpc_pkg::HALF_TURN_CD)) begin
      t_sel = t_ext - 19'(cpc_pkg::FULL_TURN_CD);
    end else if (t_ext >= -19'(cpc_pkg::HALF_TURN_CD)) begin
      t_sel = t_ext;
    end else if (t_ext >= -19'(3 * cpc_pkg::HALF_TURN_CD)) begin
      t_sel = t_ext + 19'(cpc_pkg::FULL_TURN_CD);
    end else begin
      t_sel = t_ext + 19'(2 * cpc_pkg::FULL_TURN_CD);
    end
  end

  // mirror the left half plane onto the right
  assign xa_nxt = in_x_velocity[15] ? -17'(in_x_velocity) : 17'(in_x_velocity);
  assign ya_nxt = in_x_velocity[15] ? -17'(in_y_velocity) : 17'(in_y_velocity);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    op_a_r    <= in_operation;
    omega_a_r <= in_omega;
    sqx_a_r   <= sqx_nxt;
    sqy_a_r   <= sqy_nxt;
    prod_a_r  <= prod_nxt;
    t_a_r     <= 16'(t_sel);
    xa_a_r    <= xa_nxt;
    ya_a_r    <= ya_nxt;
    neg_a_r   <= in_x_velocity[15];
    ypos_a_r  <= !in_y_velocity[15];
  end

  // fold theta into [-quarter, quarter], remember the half turn
  always_comb begin
    if (t_a_r > 16'(cpc_pkg::QUARTER_TURN_CD)) begin
      t_fold = t_a_r - 16'(cpc_pkg::HALF_TURN_CD);
      flip   = 1'b1;
    end else if (t_a_r < -16'(cpc_pkg::QUARTER_TURN_CD)) begin
      t_fold = t_a_r + 16'(cpc_pkg::HALF_TURN_CD);
      flip   = 1'b1;
    end else begin
      t_fold = t_a_r;
      flip   = 1'b0;
    end
  end

  // load the cordic word
  always_comb begin
    pipe_nxt       = '0;
    pipe_nxt.op    = op_a_r;
    pipe_nxt.omega = omega_a_r;
    if (op_a_r == cpc_pkg::OP_TO_CARTESIAN) begin
      pipe_nxt.flip = flip;
      pipe_nxt.cx   = cpc_pkg::VEC_W'(prod_a_r);
      pipe_nxt.cy   = '0;
      pipe_nxt.z    = cpc_pkg::ANG_W'(t_fold) <<< 12;
    end else begin
      pipe_nxt.flip = 1'b0;
      pipe_nxt.cx   = cpc_pkg::VEC_W'(xa_a_r) <<< 16;
      pipe_nxt.cy   = cpc_pkg::VEC_W'(ya_a_r) <<< 16;
      pipe_nxt.sq   = sqx_a_r + sqy_a_r;
      if (neg_a_r) begin
        pipe_nxt.z = ypos_a_r ? cpc_pkg::HALF_TURN_Q12 : -cpc_pkg::HALF_TURN_Q12;
      end else begin
        pipe_nxt.z = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    pipe_r <= pipe_nxt;
  end

  assign out_valid = vb_r;
  assign out_pipe  = pipe_r;

endmodule

/* rtl/core/cpc_stage.sv */
// ----------------------------------------------------------------------------
// cpc_stage: one registered cordic iteration
// Rotates the vector by the step angle of iteration ITER, steered by the
// angle sign (to cartesian) or the y sign (to polar), and in the first
// stages also resolves one bit of the square root of x*x + y*y.
// ----------------------------------------------------------------------------
module cpc_stage #(
  parameter int ITER = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  cpc_pkg::pipe_t  in_pipe,
  output logic            out_valid,
  output cpc_pkg::pipe_t  out_pipe
);

  logic                                 valid_r;
  cpc_pkg::pipe_t                       pipe_nxt, pipe_r;
  logic signed [cpc_pkg::VEC_W-1:0]     cx_in, cy_in, dx, dy;
  logic signed [cpc_pkg::ANG_W-1:0]     angle;
  logic                                 ccw, hold;
  logic [cpc_pkg::RT_W-1:0]             root_nxt;
  logic [cpc_pkg::REM_W-1:0]            rem_nxt;

  assign cx_in = in_pipe.cx;
  assign cy_in = in_pipe.cy;
  assign dx    = cy_in >>> ITER;
  assign dy    = cx_in >>> ITER;
  assign angle = cpc_pkg::ANG_W'(cpc_pkg::STEP_ANGLE[ITER]);

  // rotation direction
  always_comb begin
    if (in_pipe.op == cpc_pkg::OP_TO_CARTESIAN) begin
      ccw  = !in_pipe.z[cpc_pkg::ANG_W-1];
      hold = 1'b0;
    end else begin
      ccw  = cy_in[cpc_pkg::VEC_W-1];
      hold = (cy_in == '0);
    end
  end

  // one square root digit per stage
  generate
    if (ITER < cpc_pkg::SQRT_STEPS) begin : g_sqrt
      localparam int SB = 2 * (cpc_pkg::SQRT_STEPS - 1 - ITER);
      logic [cpc_pkg::REM_W+1:0] cur, trial;
      assign cur   = {in_pipe.rem, in_pipe.sq[SB+1:SB]};
      assign trial = {1'b0, in_pipe.root, 2'b01};
      always_comb begin
        if (cur >= trial) begin
          rem_nxt  = cpc_pkg::REM_W'(cur - trial);
          root_nxt = {in_pipe.root[cpc_pkg::RT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = cpc_pkg::REM_W'(cur);
          root_nxt = {in_pipe.root[cpc_pkg::RT_W-2:0], 1'b0};
        end
      end
    end else begin : g_nosqrt
      assign rem_nxt  = in_pipe.rem;
      assign root_nxt = in_pipe.root;
    end
  endgenerate

  // micro-rotation
  always_comb begin
    pipe_nxt      = in_pipe;
    pipe_nxt.root = root_nxt;
    pipe_nxt.rem  = rem_nxt;
    if (!hold) begin
      if (ccw) begin
        pipe_nxt.cx = cx_in - dx;
        pipe_nxt.cy = cy_in + dy;
        pipe_nxt.z  = in_pipe.z - angle;
      end else begin
        pipe_nxt.cx = cx_in + dx;
        pipe_nxt.cy = cy_in - dy;
        pipe_nxt.z  = in_pipe.z + angle;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    pipe_r <= pipe_nxt;
  end

  assign out_valid = valid_r;
  assign out_pipe  = pipe_r;

endmodule

/* rtl/core/cpc_post.sv */
// ----------------------------------------------------------------------------
// cpc_post: rounding, saturation and output register
// Rounds the angle to centidegrees and clamps it to a half turn, rounds the
// square root, undoes the half-turn fold and saturates x and y to 16 bits.
// ----------------------------------------------------------------------------
module cpc_post (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  cpc_pkg::pipe_t      in_pipe,
  output logic                out_valid,
  output logic signed [15:0]  out_x_out,
  output logic signed [15:0]  out_y_out,
  output logic [15:0]         out_rho_out,
  output logic signed [15:0]  out_theta_out,
  output logic signed [15:0]  out_omega_out
);

  logic                                 valid_r;
  logic signed [15:0]                   x_nxt, y_nxt, theta_nxt;
  logic [15:0]                          rho_nxt;
  logic signed [15:0]                   x_r, y_r, theta_r, omega_r;
  logic [15:0]                          rho_r;
  logic signed [cpc_pkg::ANG_W-1:0]     z_in, z_rnd;
  logic signed [cpc_pkg::VEC_W-1:0]     cx_in, cy_in, cx_f, cy_f, x_rnd, y_rnd;

  assign z_in  = in_pipe.z;
  assign cx_in = in_pipe.cx;
  assign cy_in = in_pipe.cy;

  // angle rounding, ties up
  assign z_rnd = (z_in + cpc_pkg::HALF_LSB_Q12) >>> 12;

  // undo the fold, round x and y
  assign cx_f  = in_pipe.flip ? -cx_in : cx_in;
  assign cy_f  = in_pipe.flip ? -cy_in : cy_in;
  assign x_rnd = (cx_f + cpc_pkg::HALF_LSB_Q24) >>> 24;
  assign y_rnd = (cy_f + cpc_pkg::HALF_LSB_Q24) >>> 24;

  always_comb begin
    x_nxt     = '0;
    y_nxt     = '0;
    rho_nxt   = '0;
    theta_nxt = '0;
    if (in_pipe.op == cpc_pkg::OP_TO_CARTESIAN) begin
      // saturate to 16-bit signed
      if (x_rnd > cpc_pkg::VEC_W'(32767)) begin
        x_nxt = 16'sd32767;
      end else if (x_rnd < -cpc_pkg::VEC_W'(32768)) begin
        x_nxt = -16'sd32768;
      end else begin
        x_nxt = 16'(x_rnd);
      end
      if (y_rnd > cpc_pkg::VEC_W'(32767)) begin
        y_nxt = 16'sd32767;
      end else if (y_rnd < -cpc_pkg::VEC_W'(32768)) begin
        y_nxt = -16'sd32768;
      end else begin
        y_nxt = 16'(y_rnd);
      end
    end else begin
      // round to nearest root
      if (in_pipe.rem > cpc_pkg::REM_W'(in_pipe.root)) begin
        rho_nxt = in_pipe.root + 16'd1;
      end else begin
        rho_nxt = in_pipe.root;
      end
      // clamp to a half turn
      if (z_rnd > cpc_pkg::ANG_W'(cpc_pkg::HALF_TURN_CD)) begin
        theta_nxt = 16'(cpc_pkg::HALF_TURN_CD);
      end else if (z_rnd < -cpc_pkg::ANG_W'(cpc_pkg::HALF_TURN_CD)) begin
        theta_nxt = -16'(cpc_pkg::HALF_TURN_CD);
      end else begin
        theta_nxt = 16'(z_rnd);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    rho_r   <= rho_nxt;
    theta_r <= theta_nxt;
    omega_r <= in_pipe.omega;
  end

  assign out_valid     = valid_r;
  assign out_x_out     = x_r;
  assign out_y_out     = y_r;
  assign out_rho_out   = rho_r;
  assign out_theta_out = theta_r;
  assign out_omega_out = omega_r;

endmodule

/* rtl/core/cartesian_polar_converter.sv */
// ----------------------------------------------------------------------------
// cartesian_polar_converter: velocity command cartesian <-> polar converter
// Fully pipelined CORDIC: two setup stages, twenty iteration stages and one
// output stage. busy stays low, so a request is taken on every cycle that
// start is high, and each result appears on out_valid after passing through
// all of these registered stages, in request order. There is one cordic
// iteration stage per step angle; the square root of the polar magnitude is
// resolved one bit per stage in the first SQRT_STEPS of them. Results are shown
// for one cycle only and cannot be held off, so the receiver must take every
// out_valid pulse.
// ----------------------------------------------------------------------------
module cartesian_polar_converter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_operation,
  input  logic signed [15:0]  in_x_velocity,
  input  logic signed [15:0]  in_y_velocity,
  input  logic [15:0]         in_rho,
  input  logic signed [16:0]  in_theta,
  input  logic signed [15:0]  in_omega,
  output logic                out_valid,
  output logic signed [15:0]  out_x_out,
  output logic signed [15:0]  out_y_out,
  output logic [15:0]         out_rho_out,
  output logic signed [15:0]  out_theta_out,
  output logic signed [15:0]  out_omega_out
);

  logic                 valid_w [0:cpc_pkg::CORDIC_STEPS];
  cpc_pkg::pipe_t       pipe_w  [0:cpc_pkg::CORDIC_STEPS];
  cpc_pkg::op_t         op;

  // the pipeline never stalls
  assign busy = 1'b0;
  assign op   = cpc_pkg::op_t'(in_operation);

  // setup stages
  cpc_prep u_prep (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (start),
    .in_operation  (op),
    .in_x_velocity (in_x_velocity),
    .in_y_velocity (in_y_velocity),
    .in_rho        (in_rho),
    .in_theta      (in_theta),
    .in_omega      (in_omega),
    .out_valid     (valid_w[0]),
    .out_pipe      (pipe_w[0])
  );

  // cordic iteration stages
  generate
    for (genvar i = 0; i < cpc_pkg::CORDIC_STEPS; i++) begin : g_stage
      cpc_stage #(
        .ITER (i)
      ) u_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_w[i]),
        .in_pipe   (pipe_w[i]),
        .out_valid (valid_w[i+1]),
        .out_pipe  (pipe_w[i+1])
      );
    end
  endgenerate

  // rounding and output register
  cpc_post u_post (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (valid_w[cpc_pkg::CORDIC_STEPS]),
    .in_pipe       (pipe_w[cpc_pkg::CORDIC_STEPS]),
    .out_valid     (out_valid),
    .out_x_out     (out_x_out),
    .out_y_out     (out_y_out),
    .out_rho_out   (out_rho_out),
    .out_theta_out (out_theta_out),
    .out_omega_out (out_omega_out)
  );

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for cartesian_polar_converter
// Sends velocity requests in both conversion modes, directed corner cases
// first and then random traffic with and without start gaps, and compares
// every out_valid pulse field by field against an in-bench fixed-point
// CORDIC predictor. Results arrive in request order and cannot be stalled.
// ----------------------------------------------------------------------------
module tb;

  // request and result records
  typedef struct {
    cpc_pkg::op_t       op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        rho;
    logic signed [16:0] theta;
    logic signed [15:0] omega;
  } vel_cmd_t;

  typedef struct {
    logic [15:0] x_out;
    logic [15:0] y_out;
    logic [15:0] rho_out;
    logic [15:0] theta_out;
    logic [15:0] omega_out;
  } vel_res_t;

  localparam longint GAIN_COMP_Q24 = 10188014;
  localparam longint HALF_TURN = 18000;
  localparam longint FULL_TURN = 36000;
  localparam longint QUARTER_TURN = 9000;
  localparam int     ROT_STEPS = 20;
  localparam int     MAX_REPORTS = 20;

  // atan(2^-i) in centidegrees, Q12
  longint atan_q12 [0:ROT_STEPS-1] = '{
    18432000, 10881045, 5749245, 2918407, 1464867,
    733147, 366663, 183343, 91673, 45837,
    22918, 11459, 5730, 2865, 1432,
    716, 358, 179, 90, 45
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_operation = 1'b0;
  logic signed [15:0] in_x_velocity = '0;
  logic signed [15:0] in_y_velocity = '0;
  logic [15:0]        in_rho = '0;
  logic signed [16:0] in_theta = '0;
  logic signed [15:0] in_omega = '0;
  logic               out_valid;
  logic signed [15:0] out_x_out;
  logic signed [15:0] out_y_out;
  logic [15:0]        out_rho_out;
  logic signed [15:0] out_theta_out;
  logic signed [15:0] out_omega_out;

  vel_res_t expected_results[$];
  int       mismatches = 0;
  int       results_checked = 0;
  int       polar_sent = 0;
  int       cart_sent = 0;

  cartesian_polar_converter dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_x_velocity (in_x_velocity),
    .in_y_velocity (in_y_velocity),
    .in_rho        (in_rho),
    .in_theta      (in_theta),
    .in_omega      (in_omega),
    .out_valid     (out_valid),
    .out_x_out     (out_x_out),
    .out_y_out     (out_y_out),
    .out_rho_out   (out_rho_out),
    .out_theta_out (out_theta_out),
    .out_omega_out (out_omega_out)
  );

  always #10 clk = ~clk;

  // rounded square root of the sum of squares
  function automatic longint round_magnitude(longint sum_sq);
    longint root;
    longint trial;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= sum_sq)
        root = trial;
    end
    if (sum_sq - root * root > root)
      root++;
    return root;
  endfunction

  // vectoring cordic, angle of (x, y) in centidegrees
  function automatic longint vector_angle(longint x, longint y);
    longint base;
    longint z;
    longint cx;
    longint cy;
    longint dx;
    longint dy;
    longint res;
    base = 0;
    z = 0;
    // left half plane: rotate by a half turn first
    if (x < 0) begin
      base = (y >= 0) ? HALF_TURN * 4096 : -HALF_TURN * 4096;
      x = -x;
      y = -y;
    end
    cx = x * 65536;
    cy = y * 65536;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy > 0) begin
        cx += dx;
        cy -= dy;
        z += atan_q12[i];
      end else if (cy < 0) begin
        cx -= dx;
        cy += dy;
        z -= atan_q12[i];
      end
    end
    res = (base + z + 2048) >>> 12;
    if (res > HALF_TURN)
      res = HALF_TURN;
    if (res < -HALF_TURN)
      res = -HALF_TURN;
    return res;
  endfunction

  function automatic longint sat16(longint v);
    if (v > 32767)
      return 32767;
    if (v < -32768)
      return -32768;
    return v;
  endfunction

  // expected result of one request
  function automatic vel_res_t convert_command(vel_cmd_t c);
    vel_res_t r;
    longint   t;
    longint   cx;
    longint   cy;
    longint   z;
    longint   dx;
    longint   dy;
    bit       flip;
    r.x_out = '0;
    r.y_out = '0;
    r.rho_out = '0;
    r.theta_out = '0;
    r.omega_out = c.omega;
    if (c.op == cpc_pkg::OP_TO_POLAR) begin
      cx = longint'(c.x);
      cy = longint'(c.y);
      r.rho_out = 16'(round_magnitude(cx * cx + cy * cy));
      r.theta_out = 16'(vector_angle(cx, cy));
    end else begin
      flip = 1'b0;
      // wrap into [-half, half) then fold into [-quarter, quarter]
      t = longint'(c.theta) % FULL_TURN;
      if (t < 0)
        t += FULL_TURN;
      if (t >= HALF_TURN)
        t -= FULL_TURN;
      if (t > QUARTER_TURN) begin
        t -= HALF_TURN;
        flip = 1'b1;
      end else if (t < -QUARTER_TURN) begin
        t += HALF_TURN;
        flip = 1'b1;
      end
      cx = longint'(c.rho) * GAIN_COMP_Q24;
      cy = 0;
      z = t * 4096;
      for (int i = 0; i < ROT_STEPS; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (z >= 0) begin
          cx -= dx;
          cy += dy;
          z -= atan_q12[i];
        end else begin
          cx += dx;
          cy -= dy;
          z += atan_q12[i];
        end
      end
      if (flip) begin
        cx = -cx;
        cy = -cy;
      end
      r.x_out = 16'(sat16((cx + (longint'(1) << 23)) >>> 24));
      r.y_out = 16'(sat16((cy + (longint'(1) << 23)) >>> 24));
    end
    return r;
  endfunction

  // request builders, unused fields get random content
  function automatic vel_cmd_t polar_cmd(int x, int y, int omega);
    vel_cmd_t c;
    c.op = cpc_pkg::OP_TO_POLAR;
    c.x = 16'(x);
    c.y = 16'(y);
    c.rho = 16'($urandom);
    c.theta = 17'($urandom);
    c.omega = 16'(omega);
    return c;
  endfunction

  function automatic vel_cmd_t cart_cmd(int rho, int theta, int omega);
    vel_cmd_t c;
    c.op = cpc_pkg::OP_TO_CARTESIAN;
    c.x = 16'($urandom);
    c.y = 16'($urandom);
    c.rho = 16'(rho);
    c.theta = 17'(theta);
    c.omega = 16'(omega);
    return c;
  endfunction

  // velocity with extra weight on extremes and small values
  function automatic int pick_velocity();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32767;
          1: return -32768;
          2: return 1;
          3: return -1;
          default: return 0;
        endcase
      end
      1, 2: return int'($urandom_range(0, 16)) - 8;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  function automatic vel_cmd_t random_command();
    int rho;
    int theta;
    if ($urandom_range(0, 1) == 0)
      return polar_cmd(pick_velocity(), pick_velocity(), pick_velocity());
    case ($urandom_range(0, 7))
      0: rho = $urandom_range(0, 65535);
      1: rho = $urandom_range(0, 20);
      default: rho = $urandom_range(0, 46341);
    endcase
    case ($urandom_range(0, 7))
      0: theta = int'($signed(17'($urandom)));
      1: theta = 4500 * (int'($urandom_range(0, 16)) - 8) + int'($urandom_range(0, 2)) - 1;
      default: theta = int'($urandom_range(0, 72000)) - 36000;
    endcase
    return cart_cmd(rho, theta, pick_velocity());
  endfunction

  // present one request and hold it until taken; start stays high
  task automatic issue_command(vel_cmd_t c);
    start <= 1'b1;
    in_operation <= c.op;
    in_x_velocity <= c.x;
    in_y_velocity <= c.y;
    in_rho <= c.rho;
    in_theta <= c.theta;
    in_omega <= c.omega;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    expected_results.push_back(convert_command(c));
    if (c.op == cpc_pkg::OP_TO_POLAR)
      polar_sent++;
    else
      cart_sent++;
  endtask

  task automatic hold_start_low(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_results_drained();
    while (expected_results.size() != 0)
      @(posedge clk);
  endtask

  // corners of the cartesian to polar direction
  task automatic test_polar_corners();
    issue_command(polar_cmd(0, 0, 32767));
    issue_command(polar_cmd(32767, 0, -32768));
    issue_command(polar_cmd(-32768, 0, 0));
    issue_command(polar_cmd(-1, 0, -1));
    issue_command(polar_cmd(0, 32767, 1));
    issue_command(polar_cmd(0, -32768, 12345));
    issue_command(polar_cmd(-32768, -32768, -2));
    issue_command(polar_cmd(32767, 32767, 7));
    issue_command(polar_cmd(-5, 1, 0));
    issue_command(polar_cmd(-5, -1, 0));
    issue_command(polar_cmd(1, -1, 0));
    issue_command(polar_cmd(-32768, 1, 0));
  endtask

  // corners of the polar to cartesian direction
  task automatic test_cartesian_corners();
    issue_command(cart_cmd(0, 0, -32768));
    issue_command(cart_cmd(46341, 0, 32767));
    issue_command(cart_cmd(46341, 9000, 0));
    issue_command(cart_cmd(46341, -9000, -1));
    issue_command(cart_cmd(46341, 18000, 1));
    issue_command(cart_cmd(46341, -18000, 0));
    issue_command(cart_cmd(40000, 36000, 0));
    issue_command(cart_cmd(40000, -36000, 0));
    issue_command(cart_cmd(65535, 4500, 0));
    issue_command(cart_cmd(65535, -13500, 0));
    issue_command(cart_cmd(1000, -65536, 0));
    issue_command(cart_cmd(1000, 65535, 0));
    issue_command(cart_cmd(12345, 27000, 0));
  endtask

  // random traffic with gap bursts, in stretches chosen at random to be gappy or gapless
  task automatic test_random_with_gaps(int count);
    bit gappy;
    gappy = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0)
        gappy = $urandom_range(0, 2) != 0;
      issue_command(random_command());
      if (gappy && $urandom_range(0, 3) == 0)
        hold_start_low($urandom_range(1, 6));
    end
  endtask

  // sender pauses until the pipeline has emptied, then resumes
  task automatic test_drain_pause();
    for (int n = 0; n < 30; n++)
      issue_command(random_command());
    start <= 1'b0;
    wait_results_drained();
    @(posedge clk);
    for (int n = 0; n < 30; n++)
      issue_command(random_command());
  endtask

  // back-to-back requests, no gaps at all
  task automatic test_random_streaming(int count);
    for (int n = 0; n < count; n++)
      issue_command(random_command());
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected 0x%h got 0x%h", $time, name, want, got);
    end
  endfunction

  // compare each result pulse with the oldest pending request
  always @(posedge clk) begin
    vel_res_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with no pending request", $time);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        check_field("x_out", want.x_out, out_x_out);
        check_field("y_out", want.y_out, out_y_out);
        check_field("rho_out", want.rho_out, out_rho_out);
        check_field("theta_out", want.theta_out, out_theta_out);
        check_field("omega_out", want.omega_out, out_omega_out);
      end
    end
  end

  // run watchdog
  initial begin
    #(20 * 400000);
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_polar_corners();
    test_cartesian_corners();
    test_random_with_gaps(600);
    test_drain_pause();
    test_random_streaming(365);
    start <= 1'b0;
    wait_results_drained();
    repeat (30) @(posedge clk);
    $display("covered %0d to-polar and %0d to-cartesian requests, %0d results compared",
             polar_sent, cart_sent, results_checked);
    $display("%0d field mismatches seen", mismatches);
    if (mismatches == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
